// ----- design/servo_bus_packet_framer_core_defines.svh -----
// assertion macros for the servo bus packet framer
// no dependencies; included by the top level only
`ifndef SERVO_BUS_PACKET_FRAMER_CORE_DEFINES_SVH
`define SERVO_BUS_PACKET_FRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define SBPF_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("sbpf assertion failed");

`define SBPF_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sbpf assertion failed");

`else

`define SBPF_ASSERT_IMPLIES(label, clk, rst, cond, prop)

`define SBPF_ASSERT_ALWAYS(label, clk, rst, prop)

`endif

`endif

// ----- design/sbpf_pkg.sv -----
// shared types and constants for the servo bus packet framer
// no dependencies
package sbpf_pkg;

   localparam int MAX_PAYLOAD = 16;
   localparam int COUNT_WIDTH = $clog2(MAX_PAYLOAD + 1);
   localparam int BYTE_WIDTH  = 8;

   localparam logic [BYTE_WIDTH-1:0] START_BYTE_RESET = 8'hFF;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] servo_id;
      logic [BYTE_WIDTH-1:0] payload_byte;
      logic                  last_byte;
   } req_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] wire_byte;
      logic                  end_of_packet;
      logic                  overflow;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_HDR0,
      ST_HDR1,
      ST_ID,
      ST_LEN,
      ST_DATA,
      ST_CSUM
   } state_type;

endpackage

// ----- design/servo_bus_packet_framer_core.sv -----
// servo bus packet framer top level: collects payload, emits framed packet
// depends on sbpf_pkg, sbpf_chain, sbpf_cell and the defines header
//
// usage: the req channel takes one payload byte per transfer with the servo
// id and a last flag; the id of the first byte of a packet is kept. bytes past
// the buffer size are dropped and mark the packet as overflowed.
// the transfer with the last flag starts emission on the rsp channel: two
// start bytes, id, length, the stored payload, then the inverted checksum
// with end_of_packet set. overflow is set on every byte of a dropped packet.
// throughput: one req transfer per cycle while collecting; a packet of n
// stored bytes is then emitted through the rsp output register, one byte
// per cycle while rsp_stall is low, during which req_stall is high.
// the last req transfer enters ST_HDR0, which feeds the output register.
// rsp_stall holds the output register and freezes emission; the req side
// reopens once the checksum is loaded, even if it is still waiting.
// csr_wr_en writes the start byte; write only while idle.
// reset (synchronous) empties the packet and sets the start byte to 0xff.
`include "servo_bus_packet_framer_core_defines.svh"

module servo_bus_packet_framer_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  sbpf_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output sbpf_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [sbpf_pkg::BYTE_WIDTH-1:0] csr_wr_data
);

   sbpf_pkg::state_type state_ff;
   sbpf_pkg::state_type state_in;

   logic [sbpf_pkg::BYTE_WIDTH-1:0]  start_ff;
   logic [sbpf_pkg::BYTE_WIDTH-1:0]  start_in;
   logic [sbpf_pkg::COUNT_WIDTH-1:0] count_ff;
   logic [sbpf_pkg::COUNT_WIDTH-1:0] count_in;
   logic [sbpf_pkg::BYTE_WIDTH-1:0]  sum_ff;
   logic [sbpf_pkg::BYTE_WIDTH-1:0]  sum_in;
   logic [sbpf_pkg::BYTE_WIDTH-1:0]  id_ff;
   logic [sbpf_pkg::BYTE_WIDTH-1:0]  id_in;
   logic                             dropped_ff;
   logic                             dropped_in;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   sbpf_pkg::rsp_type                rsp_ff;
   sbpf_pkg::rsp_type                rsp_in;

   logic                            req_xfer;
   logic                            has_room;
   logic                            advance;
   logic [sbpf_pkg::BYTE_WIDTH-1:0] len_byte;
   logic [sbpf_pkg::BYTE_WIDTH-1:0] head_data;
   sbpf_pkg::cell_ctl_type          chain_ctl;
   logic                            emit_valid;
   logic [sbpf_pkg::BYTE_WIDTH-1:0] emit_byte;
   logic                            emit_eop;

   assign req_stall = (state_ff != sbpf_pkg::ST_COLLECT);
   assign req_xfer  = req_valid && !req_stall;
   assign has_room  = (count_ff < sbpf_pkg::COUNT_WIDTH'(sbpf_pkg::MAX_PAYLOAD));
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign len_byte  = sbpf_pkg::BYTE_WIDTH'(count_ff) + sbpf_pkg::BYTE_WIDTH'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbpf_pkg::ST_COLLECT: begin
            if (req_xfer && req_data.last_byte) state_in = sbpf_pkg::ST_HDR0;
         end
         sbpf_pkg::ST_HDR0: begin
            if (advance) state_in = sbpf_pkg::ST_HDR1;
         end
         sbpf_pkg::ST_HDR1: begin
            if (advance) state_in = sbpf_pkg::ST_ID;
         end
         sbpf_pkg::ST_ID: begin
            if (advance) state_in = sbpf_pkg::ST_LEN;
         end
         sbpf_pkg::ST_LEN: begin
            if (advance) begin
               state_in = (count_ff == '0) ? sbpf_pkg::ST_CSUM : sbpf_pkg::ST_DATA;
            end
         end
         sbpf_pkg::ST_DATA: begin
            if (advance && count_ff == sbpf_pkg::COUNT_WIDTH'(1)) begin
               state_in = sbpf_pkg::ST_CSUM;
            end
         end
         sbpf_pkg::ST_CSUM: begin
            if (advance) state_in = sbpf_pkg::ST_COLLECT;
         end
         default: state_in = sbpf_pkg::ST_COLLECT;
      endcase
   end

   // emission outputs
   always_comb begin
      emit_valid = 1'b1;
      emit_eop   = 1'b0;
      emit_byte  = start_ff;
      unique case (state_ff)
         sbpf_pkg::ST_COLLECT: emit_valid = 1'b0;
         sbpf_pkg::ST_HDR0:    emit_byte  = start_ff;
         sbpf_pkg::ST_HDR1:    emit_byte  = start_ff;
         sbpf_pkg::ST_ID:      emit_byte  = id_ff;
         sbpf_pkg::ST_LEN:     emit_byte  = len_byte;
         sbpf_pkg::ST_DATA:    emit_byte  = head_data;
         sbpf_pkg::ST_CSUM: begin
            emit_byte = ~sum_ff;
            emit_eop  = 1'b1;
         end
         default:              emit_valid = 1'b0;
      endcase
   end

   assign chain_ctl.load  = req_xfer && has_room;
   assign chain_ctl.shift = (state_ff == sbpf_pkg::ST_DATA) && advance;

   // packet bookkeeping
   always_comb begin
      count_in   = count_ff;
      sum_in     = sum_ff;
      id_in      = id_ff;
      dropped_in = dropped_ff;
      if (req_xfer) begin
         if (count_ff == '0 && !dropped_ff) id_in = req_data.servo_id;
         if (has_room) begin
            count_in = count_ff + sbpf_pkg::COUNT_WIDTH'(1);
            sum_in   = sum_ff + req_data.payload_byte;
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (advance) begin
         if (state_ff == sbpf_pkg::ST_LEN) begin
            sum_in = id_ff + len_byte + sum_ff;
         end
         if (state_ff == sbpf_pkg::ST_DATA) begin
            count_in = count_ff - sbpf_pkg::COUNT_WIDTH'(1);
         end
         if (state_ff == sbpf_pkg::ST_CSUM) begin
            count_in   = '0;
            sum_in     = '0;
            id_in      = '0;
            dropped_in = 1'b0;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in         = emit_valid;
         rsp_in.wire_byte     = emit_byte;
         rsp_in.end_of_packet = emit_eop;
         rsp_in.overflow      = dropped_ff;
      end
   end

   assign start_in = csr_wr_en ? csr_wr_data : start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbpf_pkg::ST_COLLECT;
         start_ff     <= sbpf_pkg::START_BYTE_RESET;
         count_ff     <= '0;
         sum_ff       <= '0;
         id_ff        <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         id_ff        <= id_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   sbpf_chain u_chain (
      .clock     (clock),
      .ctl       (chain_ctl),
      .count     (count_ff),
      .load_data (req_data.payload_byte),
      .head_data (head_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SBPF_ASSERT_ALWAYS(a_count_bound, clock, reset,
      count_ff <= sbpf_pkg::COUNT_WIDTH'(sbpf_pkg::MAX_PAYLOAD))
   `SBPF_ASSERT_IMPLIES(a_data_nonempty, clock, reset,
      state_ff == sbpf_pkg::ST_DATA, count_ff != '0)
   `SBPF_ASSERT_IMPLIES(a_reopen_after_csum, clock, reset,
      $fell(req_stall), $past(state_ff) == sbpf_pkg::ST_CSUM)

endmodule

// ----- design/sbpf_cell.sv -----
// one payload byte cell: loads from the input or takes its neighbor's byte
// depends on sbpf_pkg
module sbpf_cell (
   input  logic                           clock,
   input  sbpf_pkg::cell_ctl_type         ctl,
   input  logic [sbpf_pkg::BYTE_WIDTH-1:0] load_data,
   input  logic [sbpf_pkg::BYTE_WIDTH-1:0] next_data,
   output logic [sbpf_pkg::BYTE_WIDTH-1:0] data
);

   logic [sbpf_pkg::BYTE_WIDTH-1:0] data_ff;
   logic [sbpf_pkg::BYTE_WIDTH-1:0] data_in;

   always_comb begin
      priority if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.shift) begin
         data_in = next_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- design/sbpf_chain.sv -----
// row of payload cells; writes land at the fill position, reads shift out at cell 0
// depends on sbpf_pkg and sbpf_cell
module sbpf_chain (
   input  logic                             clock,
   input  sbpf_pkg::cell_ctl_type           ctl,
   input  logic [sbpf_pkg::COUNT_WIDTH-1:0] count,
   input  logic [sbpf_pkg::BYTE_WIDTH-1:0]  load_data,
   output logic [sbpf_pkg::BYTE_WIDTH-1:0]  head_data
);

   logic [sbpf_pkg::BYTE_WIDTH-1:0] cell_data [sbpf_pkg::MAX_PAYLOAD];

   for (genvar i = 0; i < sbpf_pkg::MAX_PAYLOAD; i++) begin : g_cell
      sbpf_pkg::cell_ctl_type          cell_ctl;
      logic [sbpf_pkg::BYTE_WIDTH-1:0] next_data;

      assign cell_ctl.load  = ctl.load && (count == sbpf_pkg::COUNT_WIDTH'(i));
      assign cell_ctl.shift = ctl.shift;

      if (i == sbpf_pkg::MAX_PAYLOAD - 1) begin : g_tail
         assign next_data = cell_data[i];
      end else begin : g_link
         assign next_data = cell_data[i+1];
      end

      sbpf_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .load_data (load_data),
         .next_data (next_data),
         .data      (cell_data[i])
      );
   end

   assign head_data = cell_data[0];

endmodule
